### src/btas_pkg.sv
`timescale 1ns / 1ps

package btas_pkg;

  localparam int unsigned NumRegs   = 16;
  localparam int unsigned ListBits  = 16;
  localparam int unsigned ListW     = (NumRegs < ListBits) ? NumRegs : ListBits;
  localparam int unsigned CntW      = $clog2(ListW + 1);
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned PtrW      = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FillW     = $clog2(FifoDepth + 1);
  localparam logic [31:0] WordBytes = 32'd4;

  typedef struct packed {
    logic [15:0] reg_list;
    logic [3:0]  base_reg;
    logic        is_load;
    logic        write_back;
    logic        go_up;
    logic        before_req;
    logic [31:0] base_value;
  } req_t;

  typedef struct packed {
    logic        transfer_valid;
    logic [3:0]  reg_num;
    logic [31:0] word_address;
    logic        load_dir;
    logic        base_update;
    logic [31:0] new_base;
    logic        last;
  } rsp_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [ListW-1:0] list;
    logic             load;
    logic             wb;
    logic [31:0]      first_addr;
    logic [31:0]      final_base;
  } cmd_t;

endpackage

### src/btas_front.sv
`timescale 1ns / 1ps

module btas_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  btas_pkg::req_t     req_i,
  output logic               cmd_push_o,
  input  logic               cmd_full_i,
  output btas_pkg::cmd_t     cmd_o
);

  localparam int unsigned OffW = btas_pkg::CntW + 3;

  logic                         vld_q, vld_d;
  logic [btas_pkg::ListW-1:0]   list_q;
  logic                         load_q, wb_q, up_q, bef_q;
  logic [31:0]                  base_q;
  logic [btas_pkg::CntW-1:0]    cnt_q;
  logic                         accept;
  logic [OffW-1:0]              off4;
  logic signed [OffW-1:0]       delta;

  assign cmd_push_o = vld_q && !cmd_full_i;
  assign full       = vld_q && cmd_full_i;
  assign accept     = push && !full;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (cmd_push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      list_q <= req_i.reg_list[btas_pkg::ListW-1:0];
      load_q <= req_i.is_load;
      wb_q   <= req_i.write_back;
      up_q   <= req_i.go_up;
      bef_q  <= req_i.before_req;
      base_q <= req_i.base_value;
      cnt_q  <= btas_pkg::CntW'($countones(req_i.reg_list[btas_pkg::ListW-1:0]));
    end
  end

  // offset of the first word from the base
  always_comb begin
    off4 = {{(OffW - btas_pkg::CntW - 2){1'b0}}, cnt_q, 2'b00};
    if (up_q) begin
      delta = bef_q ? OffW'(4) : '0;
    end else begin
      delta = (bef_q ? '0 : OffW'(4)) - off4;
    end
  end

  always_comb begin
    cmd_o.list       = list_q;
    cmd_o.load       = load_q;
    cmd_o.wb         = wb_q;
    cmd_o.first_addr = base_q + 32'(delta);
    cmd_o.final_base = up_q ? base_q + 32'(off4) : base_q - 32'(off4);
  end

endmodule

### src/btas_cmd_fifo.sv
`timescale 1ns / 1ps

module btas_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  btas_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output btas_pkg::cmd_t data_o
);

  btas_pkg::cmd_t                 mem_q [btas_pkg::FifoDepth];
  logic [btas_pkg::PtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [btas_pkg::FillW-1:0]     fill_q, fill_d;

  function automatic logic [btas_pkg::PtrW-1:0] nxt(input logic [btas_pkg::PtrW-1:0] p);
    logic [btas_pkg::PtrW-1:0] r;
    if (p == btas_pkg::PtrW'(btas_pkg::FifoDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full_o  = fill_q == btas_pkg::FillW'(btas_pkg::FifoDepth);
  assign empty_o = fill_q == '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d   = push_i ? nxt(wr_q) : wr_q;
    rd_d   = pop_i ? nxt(rd_q) : rd_q;
    fill_d = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command queue underflow");
`endif

endmodule

### src/btas_back.sv
`timescale 1ns / 1ps

module btas_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  btas_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  logic           pop,
  output btas_pkg::rsp_t rsp_o
);

  logic                       act_q, act_d;
  logic                       out_vld_q, out_vld_d;
  logic [btas_pkg::ListW-1:0] rem_q, lsb, rem_nxt;
  logic [31:0]                addr_q, fbase_q;
  logic                       load_q, wb_q;
  logic                       slot_free, emit, is_last, any;
  logic [3:0]                 idx;
  btas_pkg::rsp_t             out_q, res;

  assign slot_free = !out_vld_q || pop;
  assign emit      = act_q && slot_free;
  assign cmd_pop_o = !act_q && cmd_valid_i;
  assign empty     = !out_vld_q;
  assign rsp_o     = out_q;

  assign lsb     = rem_q & (~rem_q + 1'b1);
  assign rem_nxt = rem_q & ~lsb;
  assign any     = rem_q != '0;
  assign is_last = rem_nxt == '0;

  always_comb begin
    idx = '0;
    for (int i = 0; i < btas_pkg::ListW; i++) begin
      if (lsb[i]) begin
        idx = idx | 4'(i);
      end
    end
  end

  always_comb begin
    res.transfer_valid = any;
    res.reg_num        = idx;
    res.word_address   = any ? addr_q : '0;
    res.load_dir       = load_q;
    res.base_update    = is_last && wb_q;
    res.new_base       = is_last ? fbase_q : '0;
    res.last           = is_last;
  end

  always_comb begin
    act_d = act_q;
    if (cmd_pop_o) begin
      act_d = 1'b1;
    end else if (emit && is_last) begin
      act_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      act_q     <= act_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      rem_q   <= cmd_i.list;
      addr_q  <= cmd_i.first_addr;
      fbase_q <= cmd_i.final_base;
      load_q  <= cmd_i.load;
      wb_q    <= cmd_i.wb;
    end else if (emit) begin
      rem_q  <= rem_nxt;
      addr_q <= addr_q + btas_pkg::WordBytes;
    end
    if (emit) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && is_last) |=> !act_q)
    else $error("sequencer still busy after last request");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !pop) |-> !emit)
    else $error("result overwritten before taken");
`endif

endmodule

### src/block_transfer_address_sequencer.sv
`timescale 1ns / 1ps
// A request is registered in the front, written to the command queue, loaded into the
// back sequencer, and each result is registered on the result side. The back sequencer
// loads each command, then steps one register per cycle while the result slot is free.
// A two-entry command queue lets the front take the next request meanwhile.
// Reset: asynchronous, clears all valid flags and empties the queue; no clearing pass.

module block_transfer_address_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  btas_pkg::req_t req_i,
  output logic           empty,
  input  logic           pop,
  output btas_pkg::rsp_t rsp_o
);

  logic           cmd_push, cmd_full, cmd_pop, cmd_empty;
  btas_pkg::cmd_t cmd_in, cmd_out;

  btas_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .req_i      (req_i),
    .cmd_push_o (cmd_push),
    .cmd_full_i (cmd_full),
    .cmd_o      (cmd_in)
  );

  btas_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  btas_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o)
  );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef btas_pkg::req_t req_t;
  typedef btas_pkg::rsp_t rsp_t;

  localparam int unsigned NumRandom   = 420;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 20;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic full;
  req_t req_i  = '0;
  logic empty;
  logic pop    = 1'b0;
  rsp_t rsp_o;

  rsp_t        xfer_q[$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 1;
  int unsigned stall_mode  = 0;
  int unsigned mode_left   = 0;
  int unsigned stall_phase = 0;

  always #5 clk_i = ~clk_i;

  block_transfer_address_sequencer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .req_i  (req_i),
    .empty  (empty),
    .pop    (pop),
    .rsp_o  (rsp_o)
  );

  function automatic void predict_transfers(req_t r);
    logic [31:0] addr;
    logic [31:0] final_base;
    int unsigned n;
    int unsigned k;
    rsp_t        t;
    n = 0;
    k = 0;
    for (int i = 0; i < btas_pkg::ListW; i++) n += r.reg_list[i];
    if (r.go_up) begin
      final_base = r.base_value + btas_pkg::WordBytes * n;
      addr = r.before_req ? r.base_value + btas_pkg::WordBytes : r.base_value;
    end else begin
      final_base = r.base_value - btas_pkg::WordBytes * n;
      addr = r.before_req ? final_base : final_base + btas_pkg::WordBytes;
    end
    if (n == 0) begin
      xfer_q.push_back(rsp_t'{1'b0, 4'd0, 32'd0, r.is_load, r.write_back, r.base_value, 1'b1});
    end else begin
      for (int i = 0; i < btas_pkg::ListW; i++) begin
        if (r.reg_list[i]) begin
          k++;
          t.transfer_valid = 1'b1;
          t.reg_num        = 4'(i);
          t.word_address   = addr;
          t.load_dir       = r.is_load;
          t.last           = (k == n);
          t.base_update    = t.last & r.write_back;
          t.new_base       = t.last ? final_base : 32'd0;
          xfer_q.push_back(t);
          addr += btas_pkg::WordBytes;
        end
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_request(req_t r, bit typed, rsp_t typed_rsp);
    push  <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (full);
    if (typed) xfer_q.push_back(typed_rsp);
    else predict_transfers(r);
    burst_left--;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && pop && !empty) begin
      if (xfer_q.size() == 0) begin
        report_mismatch("unexpected request result, reg_num", rsp_o.reg_num, '0);
      end else begin
        want = xfer_q.pop_front();
        if (rsp_o.transfer_valid !== want.transfer_valid)
          report_mismatch("transfer_valid", rsp_o.transfer_valid, want.transfer_valid);
        if (rsp_o.reg_num !== want.reg_num)
          report_mismatch("reg_num", rsp_o.reg_num, want.reg_num);
        if (rsp_o.word_address !== want.word_address)
          report_mismatch("word_address", rsp_o.word_address, want.word_address);
        if (rsp_o.load_dir !== want.load_dir)
          report_mismatch("load_dir", rsp_o.load_dir, want.load_dir);
        if (rsp_o.base_update !== want.base_update)
          report_mismatch("base_update", rsp_o.base_update, want.base_update);
        if (rsp_o.new_base !== want.new_base)
          report_mismatch("new_base", rsp_o.new_base, want.new_base);
        if (rsp_o.last !== want.last)
          report_mismatch("last", rsp_o.last, want.last);
      end
    end
  end

  // receiver: free running, coin toss, periodic gaps, heavy stalls
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    stall_phase++;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      case (stall_mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom);
        2:       pop <= (stall_phase % 4) != 0;
        default: pop <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t    dir_tab[$];
    req_t        r;
    int unsigned pick;

    // empty lists
    dir_tab.push_back(dir_row_t'{req_t'{16'h0000, 4'd0, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_1000},
                      1'b1, rsp_t'{1'b0, 4'd0, 32'h0, 1'b1, 1'b1, 32'h0000_1000, 1'b1}});
    dir_tab.push_back(dir_row_t'{req_t'{16'h0000, 4'd15, 1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF},
                      1'b1, rsp_t'{1'b0, 4'd0, 32'h0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1}});
    // single register, each addressing mode, with wrap
    dir_tab.push_back(dir_row_t'{req_t'{16'h0001, 4'd0, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_0100},
                      1'b1, rsp_t'{1'b1, 4'd0, 32'h0000_0100, 1'b1, 1'b1, 32'h0000_0104, 1'b1}});
    dir_tab.push_back(dir_row_t'{req_t'{16'h8000, 4'd1, 1'b0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFC},
                      1'b1, rsp_t'{1'b1, 4'd15, 32'h0, 1'b0, 1'b1, 32'h0, 1'b1}});
    dir_tab.push_back(dir_row_t'{req_t'{16'h8000, 4'd2, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
                      1'b1, rsp_t'{1'b1, 4'd15, 32'h0, 1'b1, 1'b0, 32'hFFFF_FFFC, 1'b1}});
    dir_tab.push_back(dir_row_t'{req_t'{16'h0001, 4'd3, 1'b0, 1'b1, 1'b0, 1'b1, 32'h0},
                      1'b1, rsp_t'{1'b1, 4'd0, 32'hFFFF_FFFC, 1'b0, 1'b1, 32'hFFFF_FFFC, 1'b1}});
    // full lists, base register in the list, odd patterns
    dir_tab.push_back(dir_row_t'{req_t'{16'hFFFF, 4'd13, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0},
                      1'b0, '0});
    dir_tab.push_back(dir_row_t'{req_t'{16'hFFFF, 4'd13, 1'b0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFC},
                      1'b0, '0});
    dir_tab.push_back(dir_row_t'{req_t'{16'hFFFF, 4'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'h8000_0000},
                      1'b0, '0});
    dir_tab.push_back(dir_row_t'{req_t'{16'hFFFF, 4'd7, 1'b0, 1'b1, 1'b0, 1'b1, 32'h0000_0020},
                      1'b0, '0});
    dir_tab.push_back(dir_row_t'{req_t'{16'h5555, 4'd0, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_4000},
                      1'b0, '0});
    dir_tab.push_back(dir_row_t'{req_t'{16'hAAAA, 4'd1, 1'b0, 1'b1, 1'b0, 1'b1, 32'h0000_4000},
                      1'b0, '0});
    dir_tab.push_back(dir_row_t'{req_t'{16'h8001, 4'd15, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0000_0004},
                      1'b0, '0});
    dir_tab.push_back(dir_row_t'{req_t'{16'h7FFE, 4'd8, 1'b0, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFF0},
                      1'b0, '0});
    dir_tab.push_back(dir_row_t'{req_t'{16'h0000, 4'd4, 1'b1, 1'b1, 1'b0, 1'b1, 32'h0},
                      1'b0, '0});
    dir_tab.push_back(dir_row_t'{req_t'{16'hFFFF, 4'd15, 1'b1, 1'b1, 1'b1, 1'b0, 32'hDEAD_BEEF},
                      1'b0, '0});
    dir_tab.push_back(dir_row_t'{req_t'{16'h0100, 4'd8, 1'b0, 1'b1, 1'b0, 1'b1, 32'h7FFF_FFFE},
                      1'b0, '0});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 40);

    foreach (dir_tab[i]) send_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);

    repeat (NumRandom) begin
      r.base_reg   = 4'($urandom);
      r.is_load    = 1'($urandom);
      r.write_back = 1'($urandom);
      r.go_up      = 1'($urandom);
      r.before_req = 1'($urandom);
      pick = $urandom_range(0, 9);
      case (pick)
        0:       r.reg_list = '0;
        1:       r.reg_list = '1;
        2, 3:    r.reg_list = 16'(1) << $urandom_range(0, 15);
        default: r.reg_list = 16'($urandom);
      endcase
      pick = $urandom_range(0, 3);
      case (pick)
        0:       r.base_value = 32'($urandom_range(0, 63));
        1:       r.base_value = 32'hFFFF_FFFF - 32'($urandom_range(0, 63));
        2:       r.base_value = $urandom & 32'hFFFF_FFFC;
        default: r.base_value = $urandom;
      endcase
      send_request(r, 1'b0, '0);
    end

    push <= 1'b0;
    while (xfer_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
